// ----- sv/hcbp_pkg.sv -----
// Package for the Huffman code bit packer: request codes, widths and sizes.
// Used by the top level and sized from MAX_CODE_LEN; depends on nothing.
package hcbp_pkg;

    // Longest code length that the table keeps; longer loads saturate to it.
    localparam int MAX_CODE_LEN = 32;

    localparam int BYTE_BITS   = 8;
    localparam int PEND_W      = BYTE_BITS - 1;
    localparam int SYM_W       = 8;
    localparam int TABLE_DEPTH = 1 << SYM_W;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int ENTRY_W     = CODE_W + LEN_W;
    localparam int VBITS_W     = 4;

    // Accumulator holds the pending bits followed by one whole code.
    localparam int ACC_W       = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W       = $clog2(ACC_W + 1);
    localparam int BURST_BYTES = ACC_W / BYTE_BITS;
    localparam int BURST_W     = BURST_BYTES * BYTE_BITS;
    localparam int CNT_W       = $clog2(BURST_BYTES + 1);
    localparam int SH_W        = $clog2(BURST_W + 1);

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

endpackage

// ----- sv/hcbp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the code table of the bit packer; no package dependency.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/huffman_code_bit_packer.sv -----
// Huffman code bit packer: code table load, MSB-first packing and flush.
// Depends on hcbp_pkg and hcbp_ram.
// The table read and the request register form stage one; results go to the burst register.
// Throughput: one item per cycle while m_ready is high and each item yields at most one
// result; an n-byte encode holds the one-byte-per-cycle result register until all are taken.
// Reset clears the accumulator and the pipeline; the code table is not cleared.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [CODE_W-1:0]    s_code_bits,
    input  logic [LEN_W-1:0]     s_code_len,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic [VBITS_W-1:0]   m_valid_bits,
    output logic                 m_last_of_run,
    output logic                 m_end_of_stream
);

    logic               s_accept;
    logic [LEN_W-1:0]   len_sat;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic               s1_valid_reg, s1_valid_next;
    logic [1:0]         s1_req_reg;

    logic [PEND_W-1:0]  pend_bits_reg, pend_bits_next;
    logic [2:0]         pend_cnt_reg, pend_cnt_next;

    logic [BURST_W-1:0] burst_word_reg, burst_word_next;
    logic [CNT_W-1:0]   burst_cnt_reg, burst_cnt_next;
    logic [VBITS_W-1:0] burst_vbits_reg, burst_vbits_next;
    logic               burst_eos_reg, burst_eos_next;

    logic [CODE_W-1:0]  ent_code, code_mask;
    logic [LEN_W-1:0]   ent_len;
    logic [ACC_W-1:0]   acc, acc_full;
    logic [TOT_W-1:0]   total;
    logic [2:0]         rem;
    logic [CNT_W-1:0]   n_bytes;
    logic [SH_W-1:0]    word_sh;
    logic [BURST_W-1:0] enc_word, flush_word;
    logic [14:0]        flush_wide;
    logic [7:0]         flush_byte;
    logic               is_encode, is_flush, s1_emits, burst_free, s1_fire, m_pop;

    assign s_accept = s_valid && s_ready;
    assign len_sat  = (s_code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : s_code_len;

    // The read data is only refreshed on acceptance, so it stays put while stage one stalls.
    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_req_type == REQ_LOAD)),
        .wr_addr (s_symbol),
        .wr_data ({s_code_bits, len_sat}),
        .rd_en   (s_accept),
        .rd_addr (s_symbol),
        .rd_data (ram_rd_data)
    );

    assign ent_code = ram_rd_data[ENTRY_W-1:LEN_W];
    assign ent_len  = ram_rd_data[LEN_W-1:0];

    always_comb begin
        code_mask = (ent_len >= LEN_W'(CODE_W)) ? '1 : ~({CODE_W{1'b1}} << ent_len);
        acc       = (ACC_W'(pend_bits_reg) << ent_len) | ACC_W'(ent_code & code_mask);
        total     = TOT_W'(pend_cnt_reg) + TOT_W'(ent_len);
        rem       = total[2:0];
        n_bytes   = CNT_W'(total >> 3);
        acc_full  = acc >> rem;
        word_sh   = SH_W'(BURST_W) - (SH_W'(n_bytes) << 3);
        enc_word  = BURST_W'(acc_full) << word_sh;

        flush_wide = 15'(pend_bits_reg) << (4'(BYTE_BITS) - {1'b0, pend_cnt_reg});
        flush_byte = flush_wide[7:0];
        flush_word = BURST_W'(flush_byte) << (BURST_W - BYTE_BITS);
    end

    assign is_encode  = s1_valid_reg && (s1_req_reg == REQ_ENCODE);
    assign is_flush   = s1_valid_reg && (s1_req_reg == REQ_FLUSH);
    assign s1_emits   = is_flush || (is_encode && (n_bytes != '0));
    assign m_pop      = m_valid && m_ready;
    assign burst_free = (burst_cnt_reg == '0) || ((burst_cnt_reg == CNT_W'(1)) && m_ready);
    assign s1_fire    = s1_valid_reg && (!s1_emits || burst_free);
    assign s_ready    = !s1_valid_reg || s1_fire;

    always_comb begin
        s1_valid_next    = s1_valid_reg;
        pend_bits_next   = pend_bits_reg;
        pend_cnt_next    = pend_cnt_reg;
        burst_word_next  = burst_word_reg;
        burst_cnt_next   = burst_cnt_reg;
        burst_vbits_next = burst_vbits_reg;
        burst_eos_next   = burst_eos_reg;

        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end

        if (m_pop) begin
            burst_word_next = burst_word_reg << BYTE_BITS;
            burst_cnt_next  = burst_cnt_reg - CNT_W'(1);
        end

        if (s1_fire && is_encode) begin
            pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            pend_cnt_next  = rem;
            if (n_bytes != '0) begin
                burst_word_next  = enc_word;
                burst_cnt_next   = n_bytes;
                burst_vbits_next = VBITS_W'(BYTE_BITS);
                burst_eos_next   = 1'b0;
            end
        end else if (s1_fire && is_flush) begin
            pend_bits_next   = '0;
            pend_cnt_next    = '0;
            burst_word_next  = flush_word;
            burst_cnt_next   = CNT_W'(1);
            burst_vbits_next = {1'b0, pend_cnt_reg};
            burst_eos_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            burst_cnt_reg <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            burst_cnt_reg <= burst_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg <= s_req_type;
        end
        burst_word_reg  <= burst_word_next;
        burst_vbits_reg <= burst_vbits_next;
        burst_eos_reg   <= burst_eos_next;
    end

    assign m_valid         = (burst_cnt_reg != '0);
    assign m_out_byte      = burst_word_reg[BURST_W-1 -: 8];
    assign m_valid_bits    = burst_vbits_reg;
    assign m_last_of_run   = (burst_cnt_reg == CNT_W'(1));
    assign m_end_of_stream = burst_eos_reg;

`ifndef NO_ASSERTIONS
    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_cnt_reg <= CNT_W'(BURST_BYTES))
        else $error("result burst longer than one code can release");

    a_eos_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_stream |-> m_last_of_run)
        else $error("flush result is not the last of its run");

    a_full_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_stream |-> m_valid_bits == VBITS_W'(BYTE_BITS))
        else $error("encode result without eight valid bits");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && is_flush |=> pend_cnt_reg == '0 && pend_bits_reg == '0)
        else $error("accumulator not cleared by flush");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && s1_emits |-> burst_cnt_reg == '0 || m_pop)
        else $error("new burst loaded over undelivered results");
`endif

endmodule

// ----- bench/tb_huffman_code_bit_packer.sv -----
// Testbench for huffman_code_bit_packer: loads code table entries, encodes and
// flushes, and checks every packed byte against a scoreboard with its own packer.
// Depends on hcbp_pkg and the RTL of the block.
module tb_huffman_code_bit_packer
    import hcbp_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int END_CYCLES  = 10;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [VBITS_W-1:0] valid_bits;
        logic               last_of_run;
        logic               end_of_stream;
    } packed_byte_t;

    class packed_byte_board;
        logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
        int unsigned       len_mem  [TABLE_DEPTH];
        logic [PEND_W-1:0] held_bits;
        int unsigned       held_count;
        packed_byte_t      bytes_due [$];
        int unsigned       mismatches;

        function new();
            held_bits  = '0;
            held_count = 0;
            mismatches = 0;
        endfunction

        // Works out the bytes that one accepted item releases.
        function void note_request(logic [1:0] req, logic [SYM_W-1:0] sym,
                                   logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
            logic [63:0]  acc;
            logic [63:0]  code_part;
            logic [15:0]  tail;
            int unsigned  nbits;
            int unsigned  total;
            packed_byte_t item;
            case (req)
                REQ_LOAD: begin
                    code_mem[sym] = code;
                    len_mem[sym]  = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
                end
                REQ_ENCODE: begin
                    nbits     = len_mem[sym];
                    code_part = {32'b0, code_mem[sym]};
                    if (nbits < 32)
                        code_part &= (64'd1 << nbits) - 64'd1;
                    acc   = ({57'b0, held_bits} << nbits) | code_part;
                    total = held_count + nbits;
                    while (total >= BYTE_BITS) begin
                        total -= BYTE_BITS;
                        item.out_byte      = 8'(acc >> total);
                        item.valid_bits    = VBITS_W'(BYTE_BITS);
                        item.last_of_run   = (total < BYTE_BITS);
                        item.end_of_stream = 1'b0;
                        bytes_due = {bytes_due, item};
                    end
                    held_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    held_count = total;
                end
                REQ_FLUSH: begin
                    // The partial byte is padded with zeros at the low end.
                    tail = {9'b0, held_bits} << (BYTE_BITS - held_count);
                    item.out_byte      = tail[7:0];
                    item.valid_bits    = VBITS_W'(held_count);
                    item.last_of_run   = 1'b1;
                    item.end_of_stream = 1'b1;
                    bytes_due = {bytes_due, item};
                    held_bits  = '0;
                    held_count = 0;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_byte(packed_byte_t got);
            packed_byte_t want;
            if (bytes_due.size() == 0) begin
                $display("%0t: result with none expected, actual byte %h bits %0d last %b eos %b",
                         $time, got.out_byte, got.valid_bits, got.last_of_run,
                         got.end_of_stream);
                mismatches++;
                return;
            end
            want = bytes_due.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("valid_bits", 8'(want.valid_bits), 8'(got.valid_bits));
            compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
            compare_field("end_of_stream", 8'(want.end_of_stream), 8'(got.end_of_stream));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [SYM_W-1:0]   s_symbol;
    logic [CODE_W-1:0]  s_code_bits;
    logic [LEN_W-1:0]   s_code_len;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_out_byte;
    logic [VBITS_W-1:0] m_valid_bits;
    logic               m_last_of_run;
    logic               m_end_of_stream;

    packed_byte_board   board = new();
    logic [SYM_W-1:0]   loaded_syms [$];
    bit                 was_loaded [TABLE_DEPTH];
    bit                 steady = 1'b0;
    int                 items_sent = 0;
    int                 cycle_count = 0;

    huffman_code_bit_packer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_symbol        (s_symbol),
        .s_code_bits     (s_code_bits),
        .s_code_len      (s_code_len),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_valid_bits    (m_valid_bits),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_stream (m_end_of_stream)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[huffman_code_bit_packer] ERROR");
            $finish;
        end
    end

    // Result side: check what was taken at this edge, then choose the next ready.
    initial begin
        packed_byte_t seen;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                seen.out_byte      = m_out_byte;
                seen.valid_bits    = m_valid_bits;
                seen.last_of_run   = m_last_of_run;
                seen.end_of_stream = m_end_of_stream;
                board.check_byte(seen);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    function automatic logic [LEN_W-1:0] rand_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return LEN_W'(MAX_CODE_LEN);
        if (roll < 30)
            return LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63));
        return LEN_W'($urandom_range(1, 12));
    endfunction

    // Only symbols with a loaded entry are ever encoded.
    function automatic logic [SYM_W-1:0] pick_loaded();
        return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    endfunction

    task automatic send_item(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        if (!steady && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_symbol    <= sym;
        s_code_bits <= code;
        s_code_len  <= len;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req, sym, code, len);
        if (req == REQ_LOAD && !was_loaded[sym]) begin
            was_loaded[sym] = 1'b1;
            loaded_syms = {loaded_syms, sym};
        end
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.bytes_due.size() != 0);
    endtask

    initial begin
        int next_drain;
        next_drain = 120;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_req_type  <= REQ_LOAD;
        s_symbol    <= '0;
        s_code_bits <= '0;
        s_code_len  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Flush on an empty accumulator, zero-length and full-length codes,
        // saturation of long lengths, masking of code bits above the length,
        // bursts of four bytes and an ignored request.
        send_item(REQ_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
        send_item(REQ_ENCODE, 8'h00, $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(REQ_ENCODE, 8'hFF, $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h5A, 32'h0000_0005, 6'd3);
        send_item(REQ_ENCODE, 8'h5A, $urandom, LEN_W'($urandom));
        send_item(REQ_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'hA5, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_ENCODE, 8'h5A, $urandom, LEN_W'($urandom));
        send_item(REQ_ENCODE, 8'hA5, $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h01, 32'hDEAD_BEEF, 6'd7);
        send_item(REQ_ENCODE, 8'h01, $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h80, 32'h0000_0001, 6'd1);
        repeat (5) send_item(REQ_ENCODE, 8'h80, $urandom, LEN_W'($urandom));
        send_item(REQ_UNUSED, 8'h5A, 32'h0, 6'd8);
        send_item(REQ_LOAD, 8'h02, 32'h8000_0001, 6'd32);
        send_item(REQ_ENCODE, 8'h02, $urandom, LEN_W'($urandom));
        send_item(REQ_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        send_item(REQ_LOAD, 8'h5A, 32'h0, 6'd8);
        send_item(REQ_ENCODE, 8'h5A, $urandom, LEN_W'($urandom));

        // Mostly runs of loads, encodes and at times a flush; the rest is single noise items.
        while (items_sent < ITEM_TARGET) begin
            steady = (items_sent >= 180 && items_sent < 260);
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain += 200;
            end
            if ($urandom_range(0, 99) < 75) begin
                repeat ($urandom_range(0, 3))
                    send_item(REQ_LOAD, SYM_W'($urandom), $urandom, rand_len());
                repeat ($urandom_range(3, 12))
                    send_item(REQ_ENCODE, pick_loaded(), $urandom, LEN_W'($urandom));
                if ($urandom_range(0, 1))
                    send_item(REQ_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: send_item(REQ_LOAD, SYM_W'($urandom), $urandom, rand_len());
                    1: send_item(REQ_ENCODE, pick_loaded(), $urandom, LEN_W'($urandom));
                    2: send_item(REQ_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                    default:
                        send_item(REQ_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                endcase
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (END_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.bytes_due.size() == 0)
            $display("[huffman_code_bit_packer] OK");
        else
            $display("[huffman_code_bit_packer] ERROR");
        $finish;
    end

endmodule
